// ----- src/owrs_pkg.sv -----
`timescale 1ns / 1ps

package owrs_pkg;

    localparam int ID_BITS    = 64;
    localparam int POS_W      = 7;   // 1-based bit position, 0 means none
    localparam int IDX_W      = 6;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 3;

    localparam logic [7:0] CMD_ALARM_SEARCH  = 8'hEC;
    localparam logic [7:0] CMD_NORMAL_SEARCH = 8'hF0;

    typedef enum logic [1:0] {
        ACT_FRESH = 2'd0,
        ACT_NEXT  = 2'd1,
        ACT_BITS  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_COMMAND  = 3'd0,
        KIND_BIT      = 3'd1,
        KIND_BIT_DONE = 3'd2,
        KIND_FINISHED = 3'd3,
        KIND_ERROR    = 3'd4
    } t_kind;

    typedef struct packed {
        t_action action;
        logic    alarm_only;
        logic    presence;
        logic    first_bit;
        logic    second_bit;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         command;
        logic               direction_bit;
        logic [ID_BITS-1:0] address;
    } t_result;

endpackage

// ----- src/owrs_in_stage.sv -----
`timescale 1ns / 1ps

module owrs_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [owrs_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [1:0]                     i_s_tuser,
    input  logic                           i_advance,
    output logic                           o_valid,
    output owrs_pkg::t_item                o_item
);
    import owrs_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_s_tready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_item.action     <= t_action'(i_s_tuser);
            r_item.alarm_only <= i_s_tdata[0];
            r_item.presence   <= i_s_tdata[1];
            r_item.first_bit  <= i_s_tdata[2];
            r_item.second_bit <= i_s_tdata[3];
        end
    end

endmodule

// ----- src/owrs_engine.sv -----
`timescale 1ns / 1ps

module owrs_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  owrs_pkg::t_item   i_item,
    output logic              o_has_result,
    output owrs_pkg::t_result o_result
);
    import owrs_pkg::*;

    logic [ID_BITS-1:0] r_previous_address, n_previous_address;
    logic [ID_BITS-1:0] r_new_address,      n_new_address;
    logic [POS_W-1:0]   r_last_discrepancy, n_last_discrepancy;
    logic [POS_W-1:0]   r_last_zero_choice, n_last_zero_choice;
    logic [IDX_W-1:0]   r_bit_position,     n_bit_position;
    logic               r_search_finished,  n_search_finished;
    logic               r_pass_active,      n_pass_active;
    logic               r_alarm_mode,       n_alarm_mode;

    logic [POS_W-1:0]   pos;
    logic               dir;

    function automatic logic [ID_BITS-1:0] swap_bytes(input logic [ID_BITS-1:0] v);
        logic [ID_BITS-1:0] r;
        for (int i = 0; i < ID_BITS / 8; i++) begin
            r[(ID_BITS / 8 - 1 - i) * 8 +: 8] = v[i * 8 +: 8];
        end
        return r;
    endfunction

    assign pos = {1'b0, r_bit_position} + POS_W'(1);

    always_comb begin
        n_previous_address = r_previous_address;
        n_new_address      = r_new_address;
        n_last_discrepancy = r_last_discrepancy;
        n_last_zero_choice = r_last_zero_choice;
        n_bit_position     = r_bit_position;
        n_search_finished  = r_search_finished;
        n_pass_active      = r_pass_active;
        n_alarm_mode       = r_alarm_mode;
        o_has_result       = 1'b0;
        o_result           = '0;
        dir                = 1'b0;

        unique case (i_item.action)
            ACT_FRESH, ACT_NEXT: begin
                if (i_item.action == ACT_FRESH) begin
                    n_previous_address = '0;
                    n_last_discrepancy = '0;
                    n_search_finished  = 1'b0;
                    n_alarm_mode       = i_item.alarm_only;
                end
                o_has_result  = 1'b1;
                n_pass_active = 1'b0;
                if (n_search_finished || !i_item.presence) begin
                    o_result.kind = KIND_FINISHED;
                end else begin
                    n_pass_active      = 1'b1;
                    n_bit_position     = '0;
                    n_new_address      = '0;
                    n_last_zero_choice = '0;
                    o_result.kind      = KIND_COMMAND;
                    o_result.command   = n_alarm_mode ? CMD_ALARM_SEARCH : CMD_NORMAL_SEARCH;
                end
            end
            ACT_BITS: begin
                if (r_pass_active) begin
                    o_has_result = 1'b1;
                    if (i_item.first_bit && i_item.second_bit) begin
                        n_pass_active = 1'b0;
                        o_result.kind = KIND_ERROR;
                    end else begin
                        if (i_item.first_bit) begin
                            dir = 1'b1;
                        end else if (i_item.second_bit) begin
                            dir = 1'b0;
                        end else begin
                            // both branches present: follow last pass below the
                            // last discrepancy, take 1 at it, 0 beyond it
                            if (pos < r_last_discrepancy) begin
                                dir = r_previous_address[r_bit_position];
                            end else begin
                                dir = (pos == r_last_discrepancy);
                            end
                            if (!dir) begin
                                n_last_zero_choice = pos;
                            end
                        end
                        n_new_address[r_bit_position] = r_new_address[r_bit_position] | dir;
                        o_result.direction_bit = dir;
                        if (pos == POS_W'(ID_BITS)) begin
                            n_previous_address = n_new_address;
                            n_last_discrepancy = n_last_zero_choice;
                            n_search_finished  = (n_last_zero_choice == '0);
                            n_pass_active      = 1'b0;
                            n_bit_position     = '0;
                            o_result.kind      = KIND_BIT_DONE;
                            o_result.address   = swap_bytes(n_new_address);
                        end else begin
                            n_bit_position = r_bit_position + IDX_W'(1);
                            o_result.kind  = KIND_BIT;
                        end
                    end
                end
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous_address <= '0;
            r_new_address      <= '0;
            r_last_discrepancy <= '0;
            r_last_zero_choice <= '0;
            r_bit_position     <= '0;
            r_search_finished  <= 1'b0;
            r_pass_active      <= 1'b0;
            r_alarm_mode       <= 1'b0;
        end else if (i_fire) begin
            r_previous_address <= n_previous_address;
            r_new_address      <= n_new_address;
            r_last_discrepancy <= n_last_discrepancy;
            r_last_zero_choice <= n_last_zero_choice;
            r_bit_position     <= n_bit_position;
            r_search_finished  <= n_search_finished;
            r_pass_active      <= n_pass_active;
            r_alarm_mode       <= n_alarm_mode;
        end
    end

endmodule

// ----- src/owrs_out_stage.sv -----
`timescale 1ns / 1ps

module owrs_out_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  owrs_pkg::t_result               i_result,
    output logic                            o_advance,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [owrs_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic [owrs_pkg::OUT_USER_W-1:0] o_m_tuser
);
    import owrs_pkg::*;

    logic    r_valid;
    t_result r_result;

    // the register frees up in the same cycle the receiver takes it
    assign o_advance  = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_result.kind;
    assign o_m_tdata  = {(OUT_DATA_W - ID_BITS - 9)'(0), r_result.address,
                         r_result.direction_bit, r_result.command};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
        if (o_advance && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- src/onewire_rom_search.sv -----
`timescale 1ns / 1ps
// 1-Wire ROM search sequencer.
// Slave channel (i_s_*): one request per bus event. tuser carries the action
// (fresh start, next pass, bit pair); tdata carries alarm_only, presence and
// the two bits read from the bus.
// Master channel (o_m_*): at most one result per request. tuser is the result
// kind (command, write bit, write bit with address, finished/absent, bus
// error); tdata holds the command byte, the direction bit to write and, after
// bit 63, the found identifier in reversed byte order.
// A request passes through an input register, then the search logic and state
// update feeding a result register. One request per cycle is sustained while
// the receiver takes results; the limit is the update of the search state.
// Bit pairs with no open pass and the unused action code give no result.
// Synchronous reset clears the search state and empties both registers.
// When the receiver stalls, the result register holds, the input register
// fills, and then o_s_tready drops until the result is taken.
module onewire_rom_search (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [0] alarm_only, [1] presence, [2] first_bit, [3] second_bit, [7:4] zero
    input  logic [owrs_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // [1:0] action
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] command, [8] direction_bit, [72:9] address, [79:73] zero
    output logic [owrs_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // [2:0] kind
    output logic [owrs_pkg::OUT_USER_W-1:0] o_m_tuser
);
    import owrs_pkg::*;

    logic    advance;
    logic    item_valid;
    t_item   item;
    logic    has_result;
    t_result result;

    owrs_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_advance  (advance),
        .o_valid    (item_valid),
        .o_item     (item)
    );

    owrs_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (item_valid && advance),
        .i_item       (item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    owrs_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (item_valid && has_result),
        .i_result   (result),
        .o_advance  (advance),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
